// ----- hdl/psts_pkg.sv -----
// shared constants, codes and types of the priority trigger state supervisor
`timescale 1ns / 1ps

package psts_pkg;

  localparam int TRIGGER_COUNT = 32;
  localparam int STATE_COUNT   = 16;

  localparam int TRIG_IDX_W  = $clog2(TRIGGER_COUNT);
  localparam int STATE_IDX_W = $clog2(STATE_COUNT);
  localparam int OP_W        = 3;
  localparam int ID_W        = 8;
  localparam int VALUE_W     = 8;
  localparam int FLAG_W      = 32;
  localparam int ERR_W       = 6;
  localparam int ERR_MAX     = 63;

  localparam int DEST_DEPTH = TRIGGER_COUNT * STATE_COUNT;
  localparam int PRIO_DEPTH = STATE_COUNT * STATE_COUNT;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // register index, taken from the word address
  localparam logic REG_TRIGGER_ENABLE = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_WR_DEST = 3'd0,
    OP_WR_PRIO = 3'd1,
    OP_WR_SID  = 3'd2,
    OP_WR_TID  = 3'd3,
    OP_EVAL    = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH,
    ST_SETTLE,
    ST_RESULT
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic issue;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic walk_last;
  } dp_status_t;

endpackage

// ----- hdl/psts_if.sv -----
// item channels of the supervisor: command items in, status items out
`timescale 1ns / 1ps

interface psts_in_if;
  logic                             valid;
  logic                             ready;
  logic [psts_pkg::OP_W-1:0]        operation;
  logic [psts_pkg::TRIG_IDX_W-1:0]  table_row;
  logic [psts_pkg::STATE_IDX_W-1:0] table_col;
  logic [psts_pkg::VALUE_W-1:0]     table_value;
  logic [psts_pkg::FLAG_W-1:0]      trigger_flags;

  modport source (
    output valid, operation, table_row, table_col, table_value, trigger_flags,
    input  ready
  );
  modport sink (
    input  valid, operation, table_row, table_col, table_value, trigger_flags,
    output ready
  );
endinterface

interface psts_out_if;
  logic                             valid;
  logic                             ready;
  logic [psts_pkg::ID_W-1:0]        state_id;
  logic [psts_pkg::STATE_IDX_W-1:0] state_index;
  logic [psts_pkg::ID_W-1:0]        trigger_id;
  logic [psts_pkg::TRIG_IDX_W-1:0]  trigger_index;
  logic                             changed;
  logic [psts_pkg::ERR_W-1:0]       lookup_errors;

  modport source (
    output valid, state_id, state_index, trigger_id, trigger_index, changed,
           lookup_errors,
    input  ready
  );
  modport sink (
    input  valid, state_id, state_index, trigger_id, trigger_index, changed,
           lookup_errors,
    output ready
  );
endinterface

// ----- hdl/psts_ram.sv -----
// generic simple dual-port ram, one write port and one registered read port
`timescale 1ns / 1ps

module psts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/psts_ctrl.sv -----
// controller: sequences table writes, the trigger walk and the result hand-off
`timescale 1ns / 1ps

module psts_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_is_eval,
  output logic                 in_ready,
  input  logic                 out_ready,
  output logic                 out_valid,
  input  psts_pkg::dp_status_t st,
  output psts_pkg::dp_cmd_t    cmd
);
  import psts_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd          = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = in_is_eval ? ST_WALK : ST_RESULT;
        end
      end
      ST_WALK: begin
        cmd.issue = 1'b1;
        if (st.walk_last) begin
          state_nxt = ST_FLUSH;
        end
      end
      // ST_FLUSH and ST_SETTLE let the last trigger leave the match and priority stages
      ST_FLUSH:  state_nxt = ST_SETTLE;
      ST_SETTLE: state_nxt = ST_RESULT;
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  assign out_valid = out_valid_r;

endmodule

// ----- hdl/psts_dp.sv -----
// datapath: tables, pipelined trigger walk, best-transition tracking and result register
`timescale 1ns / 1ps

module psts_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  psts_pkg::dp_cmd_t                cmd,
  output psts_pkg::dp_status_t             st,
  input  logic [psts_pkg::FLAG_W-1:0]      trigger_enable,
  input  logic [psts_pkg::OP_W-1:0]        operation,
  input  logic [psts_pkg::TRIG_IDX_W-1:0]  table_row,
  input  logic [psts_pkg::STATE_IDX_W-1:0] table_col,
  input  logic [psts_pkg::VALUE_W-1:0]     table_value,
  input  logic [psts_pkg::FLAG_W-1:0]      trigger_flags,
  output logic [psts_pkg::ID_W-1:0]        out_state_id,
  output logic [psts_pkg::STATE_IDX_W-1:0] out_state_index,
  output logic [psts_pkg::ID_W-1:0]        out_trigger_id,
  output logic [psts_pkg::TRIG_IDX_W-1:0]  out_trigger_index,
  output logic                             out_changed,
  output logic [psts_pkg::ERR_W-1:0]       out_lookup_errors
);
  import psts_pkg::*;

  localparam int DEST_AW = $clog2(DEST_DEPTH);
  localparam int PRIO_AW = $clog2(PRIO_DEPTH);

  // small tables in flops: state ids are compared in parallel
  logic [ID_W-1:0] sid_r [STATE_COUNT];
  logic [ID_W-1:0] tid_r [TRIGGER_COUNT];

  // architectural state
  logic [STATE_IDX_W-1:0] cur_r;
  logic [TRIG_IDX_W-1:0]  last_trig_r;
  logic [ID_W-1:0]        held_sid_r;
  logic [ID_W-1:0]        held_tid_r;

  // walk
  logic [FLAG_W-1:0]     flags_r;
  logic [TRIG_IDX_W-1:0] idx_r;

  // stage 1: destination read back
  logic                  s1_v_r;
  logic [TRIG_IDX_W-1:0] s1_idx_r;

  // stage 2: priority read back
  logic                   s2_v_r;
  logic [TRIG_IDX_W-1:0]  s2_idx_r;
  logic [STATE_IDX_W-1:0] s2_match_r;
  logic [ID_W-1:0]        s2_dest_r;

  // running best
  logic                   found_r;
  logic [VALUE_W-1:0]     best_prio_r;
  logic [TRIG_IDX_W-1:0]  best_trig_r;
  logic [STATE_IDX_W-1:0] best_state_r;
  logic [ID_W-1:0]        best_dest_r;
  logic [ERR_W-1:0]       err_r;

  // result register
  logic [ID_W-1:0]        o_sid_r;
  logic [STATE_IDX_W-1:0] o_sidx_r;
  logic [ID_W-1:0]        o_tid_r;
  logic [TRIG_IDX_W-1:0]  o_tidx_r;
  logic                   o_changed_r;
  logic [ERR_W-1:0]       o_err_r;

  logic                   dest_we, prio_we;
  logic [DEST_AW-1:0]     dest_waddr, dest_raddr;
  logic [PRIO_AW-1:0]     prio_waddr, prio_raddr;
  logic [ID_W-1:0]        dest_rdata;
  logic [VALUE_W-1:0]     prio_rdata;
  logic                   row_is_state;
  logic                   dest_hit;
  logic                   match_hit;
  logic [STATE_IDX_W-1:0] match_idx;
  logic [STATE_IDX_W-1:0] cur_nxt;
  logic [TRIG_IDX_W-1:0]  last_trig_nxt;
  logic [ID_W-1:0]        held_sid_nxt;
  logic [ID_W-1:0]        held_tid_nxt;

  assign row_is_state = (table_row < TRIG_IDX_W'(STATE_COUNT));

  always_comb begin
    dest_we = 1'b0;
    prio_we = 1'b0;
    if (cmd.accept) begin
      unique case (operation)
        OP_WR_DEST: dest_we = 1'b1;
        OP_WR_PRIO: prio_we = row_is_state;
        default: ;
      endcase
    end
  end

  assign dest_waddr = {table_row, table_col};
  assign prio_waddr = {table_row[STATE_IDX_W-1:0], table_col};
  assign dest_raddr = {idx_r, cur_r};
  assign prio_raddr = {cur_r, match_idx};

  psts_ram #(.WIDTH(ID_W), .DEPTH(DEST_DEPTH)) u_dest_ram (
    .clk   (clk),
    .we    (dest_we),
    .waddr (dest_waddr),
    .wdata (table_value),
    .raddr (dest_raddr),
    .rdata (dest_rdata)
  );

  psts_ram #(.WIDTH(VALUE_W), .DEPTH(PRIO_DEPTH)) u_prio_ram (
    .clk   (clk),
    .we    (prio_we),
    .waddr (prio_waddr),
    .wdata (table_value),
    .raddr (prio_raddr),
    .rdata (prio_rdata)
  );

  // lowest state index whose id equals the destination id
  always_comb begin
    match_hit = 1'b0;
    match_idx = '0;
    for (int j = STATE_COUNT - 1; j >= 0; j--) begin
      if (sid_r[j] == dest_rdata) begin
        match_hit = 1'b1;
        match_idx = STATE_IDX_W'(j);
      end
    end
  end

  assign dest_hit     = (dest_rdata != '0);
  assign st.walk_last = (idx_r == TRIG_IDX_W'(TRIGGER_COUNT - 1));

  // state after this item
  assign cur_nxt       = found_r ? best_state_r : cur_r;
  assign last_trig_nxt = found_r ? best_trig_r  : last_trig_r;
  assign held_sid_nxt  = found_r ? best_dest_r  : held_sid_r;
  assign held_tid_nxt  = found_r ? tid_r[best_trig_r] : held_tid_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      unique case (operation)
        OP_WR_SID: begin
          if (row_is_state) begin
            sid_r[table_row[STATE_IDX_W-1:0]] <= table_value;
          end
        end
        OP_WR_TID: tid_r[table_row] <= table_value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      last_trig_r <= '0;
      held_sid_r  <= '0;
      held_tid_r  <= '0;
      idx_r       <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      found_r     <= 1'b0;
      err_r       <= '0;
    end else begin
      if (cmd.accept) begin
        idx_r       <= '0;
        found_r     <= 1'b0;
        best_prio_r <= '0;
        err_r       <= '0;
        flags_r     <= trigger_flags;
      end else if (cmd.issue) begin
        idx_r <= idx_r + TRIG_IDX_W'(1);
      end

      // stage 0 -> 1: qualify the trigger while its destination is read
      s1_v_r   <= cmd.issue && flags_r[idx_r] && trigger_enable[idx_r];
      s1_idx_r <= idx_r;

      // stage 1 -> 2: id match while the priority is read
      s2_v_r     <= s1_v_r && dest_hit && match_hit;
      s2_idx_r   <= s1_idx_r;
      s2_match_r <= match_idx;
      s2_dest_r  <= dest_rdata;
      if (s1_v_r && dest_hit && !match_hit && (err_r != ERR_W'(ERR_MAX))) begin
        err_r <= err_r + ERR_W'(1);
      end

      // strictly greater keeps the lowest trigger on a tie
      if (s2_v_r && (prio_rdata > best_prio_r)) begin
        found_r      <= 1'b1;
        best_prio_r  <= prio_rdata;
        best_trig_r  <= s2_idx_r;
        best_state_r <= s2_match_r;
        best_dest_r  <= s2_dest_r;
      end

      if (cmd.load_out) begin
        cur_r       <= cur_nxt;
        last_trig_r <= last_trig_nxt;
        held_sid_r  <= held_sid_nxt;
        held_tid_r  <= held_tid_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      o_sid_r     <= held_sid_nxt;
      o_sidx_r    <= cur_nxt;
      o_tid_r     <= held_tid_nxt;
      o_tidx_r    <= last_trig_nxt;
      o_changed_r <= found_r;
      o_err_r     <= err_r;
    end
  end

  assign out_state_id      = o_sid_r;
  assign out_state_index   = o_sidx_r;
  assign out_trigger_id    = o_tid_r;
  assign out_trigger_index = o_tidx_r;
  assign out_changed       = o_changed_r;
  assign out_lookup_errors = o_err_r;

endmodule

// ----- hdl/priority_trigger_state_supervisor_top.sv -----
// top level of the priority trigger state supervisor
//
//  port group   dir      role
//  in_chan      sink     command items: table writes and evaluate requests
//  out_chan     source   one status item per command item
//  psel..prdata apb      trigger_enable register at byte address 0
//
// a table write goes from accept straight to the result step, an evaluate
// first walks all TRIGGER_COUNT triggers: the walk reads one destination table
// entry per cycle through the single read port of that ram.
// reset is synchronous, active low; it clears the current state and latched
// trigger, the tables hold whatever was last written.
// a result waiting on out_chan holds the block in its result step only when
// the next result is ready to go out; a new item is taken as soon as it is idle.
`timescale 1ns / 1ps

module priority_trigger_state_supervisor_top (
  input  logic                            clk,
  input  logic                            rst_n,
  psts_in_if.sink                         in_chan,
  psts_out_if.source                      out_chan,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [psts_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [psts_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [psts_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import psts_pkg::*;

  dp_cmd_t           cmd;
  dp_status_t        st;
  logic [FLAG_W-1:0] trigger_enable_r;
  logic              reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_TRIGGER_ENABLE);
  assign prdata  = reg_sel ? CFG_DATA_W'(trigger_enable_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_enable_r <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      trigger_enable_r <= FLAG_W'(pwdata);
    end
  end

  psts_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_is_eval (in_chan.operation == OP_EVAL),
    .in_ready   (in_chan.ready),
    .out_ready  (out_chan.ready),
    .out_valid  (out_chan.valid),
    .st         (st),
    .cmd        (cmd)
  );

  psts_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .trigger_enable    (trigger_enable_r),
    .operation         (in_chan.operation),
    .table_row         (in_chan.table_row),
    .table_col         (in_chan.table_col),
    .table_value       (in_chan.table_value),
    .trigger_flags     (in_chan.trigger_flags),
    .out_state_id      (out_chan.state_id),
    .out_state_index   (out_chan.state_index),
    .out_trigger_id    (out_chan.trigger_id),
    .out_trigger_index (out_chan.trigger_index),
    .out_changed       (out_chan.changed),
    .out_lookup_errors (out_chan.lookup_errors)
  );

  // one item in flight: no accept in the cycle after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("item accepted while the previous one was in progress");

  // a result only appears after the controller loaded it
  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(cmd.load_out))
    else $error("result raised without a load");

  // no more errors than triggers walked
  a_err_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.lookup_errors <= ERR_W'(TRIGGER_COUNT)))
    else $error("lookup error count beyond trigger count");

  // a load never happens while a walk is still issuing or an item is accepted
  a_load_not_walking: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !cmd.issue && !cmd.accept)
    else $error("result loaded during walk or accept");

endmodule
